// ===== hdl/fmnd_pkg.sv =====
`default_nettype none

package fmnd_pkg;

    // internal index width, covers the largest table depth plus one
    localparam int IDX_W = 21;

    localparam int LUMA_W      = 8;
    localparam int ADDR16_W    = 16;
    localparam int DIST_W      = 8;
    localparam int LIST_W      = 17;
    localparam int RANGE_W     = 2 * LIST_W;
    localparam int NBR_W       = ADDR16_W + DIST_W;

    // s_tdata field positions
    localparam int LUMA_LSB      = 0;
    localparam int PIX_ADDR_LSB  = LUMA_LSB + LUMA_W;
    localparam int ENTRY_LSB     = PIX_ADDR_LSB + ADDR16_W;
    localparam int NPIX_LSB      = ENTRY_LSB + ADDR16_W;
    localparam int NDIST_LSB     = NPIX_LSB + ADDR16_W;
    localparam int LSTART_LSB    = NDIST_LSB + DIST_W;
    localparam int LEND_LSB      = LSTART_LSB + LIST_W;
    localparam int S_TDATA_W     = 104;
    localparam int M_TDATA_W     = 8;
    localparam int FUNC_W        = 2;

    localparam int APB_DATA_W    = 32;
    localparam int CFG_ADDR_W    = 3;

    localparam logic [LUMA_W-1:0] BRIGHT_THR_RESET = 8'd40;

    localparam logic [0:0] REG_BRIGHT_THR = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PIXEL    = 2'd0,
        FUNC_NBR_WR   = 2'd1,
        FUNC_RANGE_WR = 2'd2
    } func_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_TEST  = 6'b000010,
        ST_NREAD = 6'b000100,
        ST_NCHK  = 6'b001000,
        ST_PCHK  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    typedef struct packed {
        logic                  psel;
        logic                  penable;
        logic                  pwrite;
        logic [CFG_ADDR_W-1:0] paddr;
        logic [APB_DATA_W-1:0] pwdata;
    } apb_req_t;

endpackage

`default_nettype wire

// ===== hdl/fmnd_apb_regs.sv =====
`default_nettype none

module fmnd_apb_regs (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire fmnd_pkg::apb_req_t                 apb_req,
    output logic [fmnd_pkg::APB_DATA_W-1:0]         prdata,
    output logic [fmnd_pkg::LUMA_W-1:0]             bright_thr
);

    logic [fmnd_pkg::LUMA_W-1:0] thresh_reg;
    logic [fmnd_pkg::LUMA_W-1:0] thresh_next;
    logic                        wr_en;
    logic [0:0]                  reg_idx;

    // word index: byte address divided by four
    assign reg_idx = apb_req.paddr[2];
    assign wr_en   = apb_req.psel && apb_req.penable && apb_req.pwrite;

    always_comb begin
        thresh_next = thresh_reg;
        if (wr_en && reg_idx == fmnd_pkg::REG_BRIGHT_THR) begin
            thresh_next = apb_req.pwdata[fmnd_pkg::LUMA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= fmnd_pkg::BRIGHT_THR_RESET;
        end else begin
            thresh_reg <= thresh_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            fmnd_pkg::REG_BRIGHT_THR: begin
                prdata = {{(fmnd_pkg::APB_DATA_W-fmnd_pkg::LUMA_W){1'b0}}, thresh_reg};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign bright_thr = thresh_reg;

endmodule

`default_nettype wire

// ===== hdl/frame_motion_neighbor_distance_top.sv =====
`default_nettype none
// pixel transfer when the tests fail: one table read for the test step, then one result step
// detected pixel: plus a neighbor read and check per neighbor walked, and a pixel check when
// the neighbor lies inside the frame, all stepped by the single sequencer sharing one index
// compare and the table read ports; table writes leave it idle; the result waits in an output
// register (no stall on the walk); reset (aresetn low, synchronous) is followed by a clearing
// pass over both frame banks and the list range table; s_tready stays low during the pass

module frame_motion_neighbor_distance_top #(
    parameter int FRAME_PIXELS     = 65536,
    parameter int NEIGHBOR_ENTRIES = 65536
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // luma[7:0], pixel_addr[23:8], entry_addr[39:24], neighbor_pixel[55:40],
    // neighbor_distance[63:56], list_start[80:64], list_end[97:81], zero[103:98]
    input  wire logic [fmnd_pkg::S_TDATA_W-1:0]     s_tdata,
    // func[1:0]
    input  wire logic [fmnd_pkg::FUNC_W-1:0]        s_tuser,
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // distance_code[7:0]
    output logic [fmnd_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                    m_tlast,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [fmnd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [fmnd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [fmnd_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready
);

    localparam int IDX_W  = fmnd_pkg::IDX_W;
    localparam int PIX_AW = $clog2(FRAME_PIXELS);
    localparam int ENT_AW = $clog2(NEIGHBOR_ENTRIES);
    localparam int LW     = fmnd_pkg::LUMA_W;
    localparam int DW     = fmnd_pkg::DIST_W;
    localparam int LSW    = fmnd_pkg::LIST_W;
    localparam int A16    = fmnd_pkg::ADDR16_W;
    localparam logic [IDX_W-1:0]  FP_EXT    = IDX_W'(FRAME_PIXELS);
    localparam logic [IDX_W-1:0]  NE_EXT    = IDX_W'(NEIGHBOR_ENTRIES);
    localparam logic [PIX_AW-1:0] CLR_LAST  = PIX_AW'(FRAME_PIXELS - 1);

    // configuration
    fmnd_pkg::apb_req_t apb_req;
    logic [LW-1:0]      bright_thr;

    assign apb_req.psel    = psel;
    assign apb_req.penable = penable;
    assign apb_req.pwrite  = pwrite;
    assign apb_req.paddr   = paddr;
    assign apb_req.pwdata  = pwdata;
    assign pready          = 1'b1;

    fmnd_apb_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .apb_req    (apb_req),
        .prdata     (prdata),
        .bright_thr (bright_thr)
    );

    // input fields
    logic [LW-1:0]  in_luma;
    logic [A16-1:0] in_pix_addr;
    logic [A16-1:0] in_entry;
    logic [A16-1:0] in_npix;
    logic [DW-1:0]  in_ndist;
    logic [LSW-1:0] in_lstart;
    logic [LSW-1:0] in_lend;

    assign in_luma     = s_tdata[fmnd_pkg::LUMA_LSB +: LW];
    assign in_pix_addr = s_tdata[fmnd_pkg::PIX_ADDR_LSB +: A16];
    assign in_entry    = s_tdata[fmnd_pkg::ENTRY_LSB +: A16];
    assign in_npix     = s_tdata[fmnd_pkg::NPIX_LSB +: A16];
    assign in_ndist    = s_tdata[fmnd_pkg::NDIST_LSB +: DW];
    assign in_lstart   = s_tdata[fmnd_pkg::LSTART_LSB +: LSW];
    assign in_lend     = s_tdata[fmnd_pkg::LEND_LSB +: LSW];

    // control state
    fmnd_pkg::state_t   state_reg, state_next;
    logic               clr_reg, clr_next;
    logic [PIX_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [PIX_AW-1:0]  pix_cnt_reg, pix_cnt_next;
    logic               bank_reg, bank_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // payload
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [LSW-1:0]     end_reg, end_next;
    logic [DW-1:0]      code_reg, code_next;
    logic [DW-1:0]      dist_reg, dist_next;
    logic [LW-1:0]      cur_reg, cur_next;
    logic               last_reg, last_next;
    logic [DW-1:0]      m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;

    // memories
    logic [LW-1:0]                frm0_mem [FRAME_PIXELS];
    logic [LW-1:0]                frm1_mem [FRAME_PIXELS];
    logic [fmnd_pkg::RANGE_W-1:0] rng_mem  [FRAME_PIXELS];
    logic [fmnd_pkg::NBR_W-1:0]   nbr_mem  [NEIGHBOR_ENTRIES];

    logic [LW-1:0]                frm0_rd_reg, frm1_rd_reg;
    logic [fmnd_pkg::RANGE_W-1:0] rng_rd_reg;
    logic [fmnd_pkg::NBR_W-1:0]   nbr_rd_reg;

    logic                         s_acc;
    logic                         pix_wr;
    logic                         frm0_we, frm1_we;
    logic [PIX_AW-1:0]            frm_wr_addr;
    logic [LW-1:0]                frm_wr_data;
    logic [PIX_AW-1:0]            frm_rd_addr;
    logic                         rng_we;
    logic [PIX_AW-1:0]            rng_wr_addr;
    logic [fmnd_pkg::RANGE_W-1:0] rng_wr_data;
    logic                         nbr_we;

    logic [IDX_W-1:0]             pix_addr_ext;
    logic [IDX_W-1:0]             entry_ext;
    logic [IDX_W-1:0]             lend_ext;
    logic [IDX_W-1:0]             lend_clamp;

    logic [LSW-1:0]               rng_start;
    logic [LSW-1:0]               rng_end;
    logic [LW-1:0]                prev_rd;
    logic [LW-1:0]                rise;
    logic                         luma_pass;
    logic [IDX_W-1:0]             cmp_a;
    logic [IDX_W-1:0]             cmp_b;
    logic                         cmp_lt;
    logic [IDX_W-1:0]             npos_ext;
    logic                         npos_in_frame;
    logic                         out_free;
    logic [IDX_W-1:0]             pix_cnt_inc;

    assign s_tready = (state_reg == fmnd_pkg::ST_IDLE) && !clr_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign pix_wr   = s_acc && (s_tuser == fmnd_pkg::FUNC_PIXEL);

    assign pix_addr_ext = {{(IDX_W-A16){1'b0}}, in_pix_addr};
    assign entry_ext    = {{(IDX_W-A16){1'b0}}, in_entry};
    assign lend_ext     = {{(IDX_W-LSW){1'b0}}, in_lend};
    // list end clipped to the table depth when stored
    assign lend_clamp   = (lend_ext > NE_EXT) ? NE_EXT : lend_ext;

    // frame banks: previous is bank_reg, current is the other one
    assign frm0_we     = clr_reg || (pix_wr && bank_reg);
    assign frm1_we     = clr_reg || (pix_wr && !bank_reg);
    assign frm_wr_addr = clr_reg ? clr_cnt_reg : pix_cnt_reg;
    assign frm_wr_data = clr_reg ? '0 : in_luma;

    assign rng_we      = clr_reg || (s_acc && (s_tuser == fmnd_pkg::FUNC_RANGE_WR)
                                     && (pix_addr_ext < FP_EXT));
    assign rng_wr_addr = clr_reg ? clr_cnt_reg : pix_addr_ext[PIX_AW-1:0];
    assign rng_wr_data = clr_reg ? '0 : {in_lstart, lend_clamp[LSW-1:0]};

    assign nbr_we = s_acc && (s_tuser == fmnd_pkg::FUNC_NBR_WR) && (entry_ext < NE_EXT);

    always_ff @(posedge aclk) begin
        if (frm0_we) begin
            frm0_mem[frm_wr_addr] <= frm_wr_data;
        end
        frm0_rd_reg <= frm0_mem[frm_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (frm1_we) begin
            frm1_mem[frm_wr_addr] <= frm_wr_data;
        end
        frm1_rd_reg <= frm1_mem[frm_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (rng_we) begin
            rng_mem[rng_wr_addr] <= rng_wr_data;
        end
        rng_rd_reg <= rng_mem[pix_cnt_reg];
    end

    always_ff @(posedge aclk) begin
        if (nbr_we) begin
            nbr_mem[entry_ext[ENT_AW-1:0]] <= {in_npix, in_ndist};
        end
        nbr_rd_reg <= nbr_mem[k_reg[ENT_AW-1:0]];
    end

    // test and walk datapath
    assign rng_start = rng_rd_reg[fmnd_pkg::RANGE_W-1:LSW];
    assign rng_end   = rng_rd_reg[LSW-1:0];
    assign prev_rd   = bank_reg ? frm1_rd_reg : frm0_rd_reg;
    assign rise      = cur_reg - prev_rd;
    // prev <= thr <= cur, so the rise never wraps when all three pass
    assign luma_pass = (cur_reg >= bright_thr) && (prev_rd <= bright_thr)
                       && (rise >= bright_thr);

    // shared index compare: list start in the test step, walk index otherwise
    always_comb begin
        if (state_reg == fmnd_pkg::ST_TEST) begin
            cmp_a = {{(IDX_W-LSW){1'b0}}, rng_start};
            cmp_b = {{(IDX_W-LSW){1'b0}}, rng_end};
        end else begin
            cmp_a = k_reg;
            cmp_b = {{(IDX_W-LSW){1'b0}}, end_reg};
        end
    end
    assign cmp_lt = cmp_a < cmp_b;

    assign npos_ext      = {{(IDX_W-A16){1'b0}}, nbr_rd_reg[fmnd_pkg::NBR_W-1:DW]};
    assign npos_in_frame = npos_ext < FP_EXT;
    assign out_free      = !m_tvalid_reg || m_tready;
    assign pix_cnt_inc   = {{(IDX_W-PIX_AW){1'b0}}, pix_cnt_reg} + IDX_W'(1);

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        clr_cnt_next  = clr_cnt_reg;
        pix_cnt_next  = pix_cnt_reg;
        bank_next     = bank_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        k_next        = k_reg;
        end_next      = end_reg;
        code_next     = code_reg;
        dist_next     = dist_reg;
        cur_next      = cur_reg;
        last_next     = last_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        frm_rd_addr   = pix_cnt_reg;

        if (clr_reg) begin
            clr_cnt_next = clr_cnt_reg + PIX_AW'(1);
            if (clr_cnt_reg == CLR_LAST) begin
                clr_next = 1'b0;
            end
        end

        unique case (state_reg)
            fmnd_pkg::ST_IDLE: begin
                if (pix_wr) begin
                    cur_next   = in_luma;
                    last_next  = s_tlast;
                    state_next = fmnd_pkg::ST_TEST;
                end
            end
            fmnd_pkg::ST_TEST: begin
                end_next  = rng_end;
                code_next = '0;
                if (cmp_lt && luma_pass) begin
                    k_next     = {{(IDX_W-LSW){1'b0}}, rng_start};
                    state_next = fmnd_pkg::ST_NREAD;
                end else begin
                    state_next = fmnd_pkg::ST_DONE;
                end
            end
            fmnd_pkg::ST_NREAD: begin
                k_next     = k_reg + IDX_W'(1);
                state_next = fmnd_pkg::ST_NCHK;
            end
            fmnd_pkg::ST_NCHK: begin
                dist_next = nbr_rd_reg[DW-1:0];
                if (npos_in_frame) begin
                    frm_rd_addr = npos_ext[PIX_AW-1:0];
                    state_next  = fmnd_pkg::ST_PCHK;
                end else if (cmp_lt) begin
                    state_next = fmnd_pkg::ST_NREAD;
                end else begin
                    state_next = fmnd_pkg::ST_DONE;
                end
            end
            fmnd_pkg::ST_PCHK: begin
                if (prev_rd != '0) begin
                    code_next  = dist_reg;
                    state_next = fmnd_pkg::ST_DONE;
                end else if (cmp_lt) begin
                    state_next = fmnd_pkg::ST_NREAD;
                end else begin
                    state_next = fmnd_pkg::ST_DONE;
                end
            end
            fmnd_pkg::ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = code_reg;
                    m_tlast_next  = last_reg;
                    if (last_reg) begin
                        pix_cnt_next = '0;
                        bank_next    = !bank_reg;
                    end else if (pix_cnt_inc >= FP_EXT) begin
                        pix_cnt_next = '0;
                    end else begin
                        pix_cnt_next = pix_cnt_inc[PIX_AW-1:0];
                    end
                    state_next = fmnd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fmnd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fmnd_pkg::ST_IDLE;
            clr_reg      <= 1'b1;
            clr_cnt_reg  <= '0;
            pix_cnt_reg  <= '0;
            bank_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            clr_cnt_reg  <= clr_cnt_next;
            pix_cnt_reg  <= pix_cnt_next;
            bank_reg     <= bank_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg       <= k_next;
        end_reg     <= end_next;
        code_reg    <= code_next;
        dist_reg    <= dist_next;
        cur_reg     <= cur_next;
        last_reg    <= last_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTH
    // no transfer is taken while the clearing pass runs
    a_clr_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_reg |-> !s_tready)
        else $error("input taken during clearing pass");

    // walk index never runs past the list end
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fmnd_pkg::ST_NCHK) |-> (k_reg <= {{(IDX_W-LSW){1'b0}}, end_reg}))
        else $error("walk index beyond list end");

    // a finished pixel with a free output slot always produces a result
    a_done_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fmnd_pkg::ST_DONE && out_free) |=> m_tvalid)
        else $error("finished pixel did not produce a result");

    // a walk only starts from a pixel that passed the tests with a non-empty list
    a_walk_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fmnd_pkg::ST_TEST && !(cmp_lt && luma_pass))
        |=> (state_reg == fmnd_pkg::ST_DONE))
        else $error("walk started without passing tests");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_frame_motion_neighbor_distance_top.sv =====
`timescale 1ns / 1ps

module tb_frame_motion_neighbor_distance_top;

    localparam int N_PIX = 65536;
    localparam int N_ENT = 65536;
    localparam int FW  = fmnd_pkg::FUNC_W;
    localparam int LW  = fmnd_pkg::LUMA_W;
    localparam int AW  = fmnd_pkg::ADDR16_W;
    localparam int DW  = fmnd_pkg::DIST_W;
    localparam int LSW = fmnd_pkg::LIST_W;
    localparam int SDW = fmnd_pkg::S_TDATA_W;
    localparam int CAW = fmnd_pkg::CFG_ADDR_W;
    localparam int PDW = fmnd_pkg::APB_DATA_W;
    localparam logic [FW-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [CAW-1:0] THR_ADDR = {fmnd_pkg::REG_BRIGHT_THR, 2'b00};
    localparam int SETTLE_CYCLES = 16;

    typedef struct {
        logic [FW-1:0]  func;
        logic [LW-1:0]  luma;
        logic           last;
        logic [AW-1:0]  pix;
        logic [AW-1:0]  entry;
        logic [AW-1:0]  npix;
        logic [DW-1:0]  ndist;
        logic [LSW-1:0] lstart;
        logic [LSW-1:0] lend;
        bit             drain;
    } stream_item_t;

    typedef struct {
        logic [DW-1:0] code;
        logic          last;
    } px_result_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [SDW-1:0]                  s_tdata = '0;
    logic [FW-1:0]                   s_tuser = '0;
    logic                            s_tlast = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b1;
    logic [fmnd_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tlast;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [CAW-1:0]                  paddr = '0;
    logic [PDW-1:0]                  pwdata = '0;
    logic [PDW-1:0]                  prdata;
    logic                            pready;

    // stimulus side
    stream_item_t pending[$];
    bit           nbr_set[N_ENT];
    int           sent = 0;
    bit           calm = 1'b0;
    int           gap_left = 0;
    int           stall_left = 0;
    bit           s_fire = 1'b0;
    bit           m_fire = 1'b0;

    // predicted state of the block
    bit [LW-1:0]   frame_bank[2][N_PIX];
    bit            bank_sel = 1'b0;
    bit [15:0]     pix_count = '0;
    bit [LSW-1:0]  rng_lo[N_PIX];
    bit [LSW-1:0]  rng_hi[N_PIX];
    bit [AW-1:0]   nbr_pos[N_ENT];
    bit [DW-1:0]   nbr_dist[N_ENT];
    logic [LW-1:0] thr_now = fmnd_pkg::BRIGHT_THR_RESET;
    px_result_t    distance_q[$];
    int            errors = 0;

    frame_motion_neighbor_distance_top #(
        .FRAME_PIXELS    (N_PIX),
        .NEIGHBOR_ENTRIES(N_ENT)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (errors < 40) begin
            $display("mismatch at %0t: %s", $time, what);
        end
        errors++;
    endtask

    // table updates, or motion test and neighbor walk, for one accepted transfer
    task automatic track_motion(input logic [FW-1:0] f, input logic [SDW-1:0] d,
                                input logic lst);
        int idx, cur, prev, lo, hi, thr;
        logic [DW-1:0] code;
        px_result_t r;
        case (f)
            fmnd_pkg::FUNC_NBR_WR: begin
                nbr_pos[d[fmnd_pkg::ENTRY_LSB +: AW]] = d[fmnd_pkg::NPIX_LSB +: AW];
                nbr_dist[d[fmnd_pkg::ENTRY_LSB +: AW]] = d[fmnd_pkg::NDIST_LSB +: DW];
            end
            fmnd_pkg::FUNC_RANGE_WR: begin
                rng_lo[d[fmnd_pkg::PIX_ADDR_LSB +: AW]] = d[fmnd_pkg::LSTART_LSB +: LSW];
                rng_hi[d[fmnd_pkg::PIX_ADDR_LSB +: AW]] = d[fmnd_pkg::LEND_LSB +: LSW];
            end
            fmnd_pkg::FUNC_PIXEL: begin
                idx = int'(pix_count);
                thr = int'(thr_now);
                cur = int'(d[fmnd_pkg::LUMA_LSB +: LW]);
                prev = int'(frame_bank[bank_sel][idx]);
                lo = int'(rng_lo[idx]);
                hi = int'(rng_hi[idx]);
                if (hi > N_ENT) hi = N_ENT;
                code = '0;
                if (lo < hi && cur >= thr && prev <= thr && cur - prev >= thr) begin
                    // 16-bit neighbor positions always fall inside the frame
                    for (int k = lo; k < hi; k++) begin
                        if (frame_bank[bank_sel][nbr_pos[k]] != 0) begin
                            code = nbr_dist[k];
                            break;
                        end
                    end
                end
                frame_bank[!bank_sel][idx] = cur[LW-1:0];
                if (lst) begin
                    pix_count = '0;
                    bank_sel = !bank_sel;
                end else begin
                    // frame size equals the counter range, so overrun wraps by itself
                    pix_count = pix_count + 16'd1;
                end
                r.code = code;
                r.last = lst;
                distance_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    // ---------------- driver ----------------
    always @(negedge aclk) begin : drive
        stream_item_t it;
        logic [SDW-1:0] d;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (gap_left != 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending.size() != 0 &&
                         !(pending[0].drain && distance_q.size() != 0)) begin
                it = pending.pop_front();
                d = '0;
                d[fmnd_pkg::LUMA_LSB +: LW] = it.luma;
                d[fmnd_pkg::PIX_ADDR_LSB +: AW] = it.pix;
                d[fmnd_pkg::ENTRY_LSB +: AW] = it.entry;
                d[fmnd_pkg::NPIX_LSB +: AW] = it.npix;
                d[fmnd_pkg::NDIST_LSB +: DW] = it.ndist;
                d[fmnd_pkg::LSTART_LSB +: LSW] = it.lstart;
                d[fmnd_pkg::LEND_LSB +: LSW] = it.lend;
                s_tdata <= d;
                s_tuser <= it.func;
                s_tlast <= it.last;
                s_tvalid <= 1'b1;
                gap_left <= calm ? 0 : $urandom_range(0, 7);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- result sink ----------------
    always @(negedge aclk) begin : sink
        int w;
        w = stall_left;
        if (m_fire) begin
            w = calm ? 0 : $urandom_range(0, 7);
        end else if (w != 0) begin
            w = w - 1;
        end
        stall_left <= w;
        m_tready <= (w == 0);
    end

    // ---------------- monitor ----------------
    always @(posedge aclk) begin : watch
        px_result_t want;
        s_fire <= s_tvalid && s_tready;
        m_fire <= m_tvalid && m_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                track_motion(s_tuser, s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (distance_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d with nothing expected", m_tdata));
                end else begin
                    want = distance_q.pop_front();
                    if (m_tdata !== want.code) begin
                        report_mismatch($sformatf("distance_code %0d, want %0d",
                                                  m_tdata, want.code));
                    end
                    if (m_tlast !== want.last) begin
                        report_mismatch($sformatf("frame_last %b, want %b",
                                                  m_tlast, want.last));
                    end
                end
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    function automatic stream_item_t blank_item();
        stream_item_t it;
        it.func = FUNC_UNUSED;
        it.luma = LW'($urandom_range(0, 255));
        it.last = 1'($urandom_range(0, 1));
        it.pix = AW'($urandom_range(0, 65535));
        it.entry = AW'($urandom_range(0, 65535));
        it.npix = AW'($urandom_range(0, 65535));
        it.ndist = DW'($urandom_range(0, 255));
        it.lstart = LSW'($urandom_range(0, 65536));
        it.lend = LSW'($urandom_range(0, 65536));
        it.drain = ($urandom_range(0, 39) == 0);
        return it;
    endfunction

    function automatic int near_pixel();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 15);
    endfunction

    function automatic int pick_luma();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return $urandom_range(0, thr_now);
            2: return $urandom_range(thr_now, 255);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic push_nbr(input int e, input int p, input int nd);
        stream_item_t it;
        it = blank_item();
        it.func = fmnd_pkg::FUNC_NBR_WR;
        it.entry = AW'(e);
        it.npix = AW'(p);
        it.ndist = DW'(nd);
        nbr_set[e] = 1'b1;
        pending.push_back(it);
        sent++;
    endtask

    // entries of a non-empty list are written first, so the walk never reads a blank entry
    task automatic push_range(input int p, input int lo, input int hi);
        stream_item_t it;
        for (int k = lo; k < hi && k < N_ENT; k++) begin
            if (!nbr_set[k]) push_nbr(k, near_pixel(), $urandom_range(0, 255));
        end
        it = blank_item();
        it.func = fmnd_pkg::FUNC_RANGE_WR;
        it.pix = AW'(p);
        it.lstart = LSW'(lo);
        it.lend = LSW'(hi);
        pending.push_back(it);
        sent++;
    endtask

    task automatic push_pixel(input int luma, input bit last);
        stream_item_t it;
        it = blank_item();
        it.func = fmnd_pkg::FUNC_PIXEL;
        it.luma = LW'(luma);
        it.last = last;
        pending.push_back(it);
        sent++;
    endtask

    task automatic push_short_list(input int p);
        int lo, hi;
        case ($urandom_range(0, 15))
            0: begin
                lo = $urandom_range(N_ENT - 6, N_ENT);
                hi = N_ENT;
            end
            1: begin
                lo = $urandom_range(1, 65536);
                hi = $urandom_range(0, lo);
            end
            default: begin
                lo = $urandom_range(0, 60);
                hi = lo + $urandom_range(0, 4);
            end
        endcase
        push_range(p, lo, hi);
    endtask

    task automatic settle();
        do @(posedge aclk); while (pending.size() != 0 || s_tvalid || distance_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_threshold(input logic [LW-1:0] v);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= THR_ADDR;
        pwdata <= {{(PDW-LW){1'b0}}, v};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        thr_now = v;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {{(PDW-LW){1'b0}}, v}) begin
            report_mismatch($sformatf("threshold reads %0h, want %0h", prdata, v));
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // mostly whole frames with fresh lists, plus noise and frames cut short
    task automatic run_frames(input int n);
        int target, len;
        target = sent + n;
        while (sent < target) begin
            case ($urandom_range(0, 19))
                14: pending.push_back(blank_item());
                15: push_nbr($urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 255));
                16: push_short_list($urandom_range(0, 65535));
                17, 18: repeat ($urandom_range(1, 3)) push_pixel(pick_luma(), 1'b0);
                19: push_pixel(pick_luma(), 1'b1);
                default: begin
                    len = $urandom_range(2, 12);
                    repeat ($urandom_range(0, 3)) push_short_list($urandom_range(0, len - 1));
                    if ($urandom_range(0, 2) == 0) begin
                        push_nbr($urandom_range(0, 63), near_pixel(), $urandom_range(0, 255));
                    end
                    for (int i = 0; i < len; i++) push_pixel(pick_luma(), i == len - 1);
                end
            endcase
        end
        push_pixel(pick_luma(), 1'b1);
    endtask

    // ---------------- sequence ----------------
    initial begin : stimulus
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        push_nbr(0, 1, 200);
        push_nbr(1, 2, 77);
        push_nbr(N_ENT - 2, 0, 1);
        push_nbr(N_ENT - 1, 16'hFFFF, 255);
        pending.push_back(blank_item());        // unused func, no result
        push_range(0, 0, 2);
        push_range(1, N_ENT - 2, N_ENT);        // list runs to the table end
        push_range(2, 5, 3);                    // reversed list is empty
        push_range(3, 0, 2);
        push_range(N_PIX - 1, 0, 1);
        // first frame sees an all-zero previous bank
        push_pixel(255, 1'b0);
        push_pixel(0, 1'b0);
        push_pixel(100, 1'b0);
        push_pixel(40, 1'b1);
        // rise exactly at threshold, bright previous, falling luma
        push_pixel(255, 1'b0);
        push_pixel(40, 1'b0);
        push_pixel(10, 1'b0);
        push_pixel(30, 1'b1);
        push_pixel(45, 1'b0);
        push_pixel(80, 1'b0);
        push_pixel(0, 1'b0);
        push_pixel(100, 1'b1);
        settle();

        set_threshold(8'd0);
        run_frames(80);
        settle();
        set_threshold(8'd255);
        run_frames(80);
        settle();
        calm = 1'b1;
        set_threshold(LW'($urandom_range(1, 254)));
        run_frames(80);
        settle();
        calm = 1'b0;
        repeat (2) begin
            set_threshold(LW'($urandom_range(1, 254)));
            run_frames(80);
            settle();
        end
        set_threshold(fmnd_pkg::BRIGHT_THR_RESET);
        run_frames(80);
        settle();

        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/fmnd_pkg.sv
hdl/fmnd_apb_regs.sv
hdl/frame_motion_neighbor_distance_top.sv
sim/tb_frame_motion_neighbor_distance_top.sv
